// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Bodies are empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/lps_pkg.sv
package lps_pkg;

  // Table size default and fixed limits.
  localparam int MAX_PROCS_DEF = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int RES_W         = $clog2(MAX_RESULTS + 1);
  localparam int WEIGHT_MAX    = 3;
  localparam int DRAW_W        = 16;
  localparam int TICK_W        = 16;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_LOW_WEIGHT    = 2'd0;
  localparam logic [1:0] REG_NORMAL_WEIGHT = 2'd1;
  localparam logic [1:0] REG_HIGH_WEIGHT   = 2'd2;

  // Priority codes.
  localparam logic [1:0] PRIO_LOW     = 2'd0;
  localparam logic [1:0] PRIO_NORMAL  = 2'd1;
  localparam logic [1:0] PRIO_HIGH    = 2'd2;
  localparam logic [1:0] PRIO_UNKNOWN = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_SELECTED = 2'd0;
  localparam logic [1:0] KIND_WAITING  = 2'd1;
  localparam logic [1:0] KIND_IDLE     = 2'd2;

  // One process table entry as held in the memory.
  typedef struct packed {
    logic [7:0]        id;
    logic [TICK_W-1:0] arrival;
    logic [15:0]       remaining;
    logic [1:0]        prio;
    logic              done;
  } entry_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_DIVIDE,
    ST_WINNER,
    ST_WRBACK,
    ST_LIST_RD,
    ST_LIST_EV,
    ST_FINISH
  } state_t;

  // An entry takes part once it has arrived and is not finished.
  function automatic logic entry_eligible(entry_t e, logic [TICK_W-1:0] tick);
    return !e.done && (e.arrival <= tick);
  endfunction

  // Tickets an entry holds on the current tick.
  function automatic logic [1:0] entry_tickets(entry_t e, logic [TICK_W-1:0] tick,
                                               logic [1:0] w_low, logic [1:0] w_norm,
                                               logic [1:0] w_high);
    logic [1:0] w;
    case (e.prio)
      PRIO_LOW:    w = w_low;
      PRIO_NORMAL: w = w_norm;
      PRIO_HIGH:   w = w_high;
      default:     w = 2'd0;
    endcase
    return entry_eligible(e, tick) ? w : 2'd0;
  endfunction

endpackage

// File: rtl/lps_if.sv
// Input channel: load commands and scheduling ticks.
interface lps_in_if;
  import lps_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [7:0]        process_id;
  logic [TICK_W-1:0] arrival_tick;
  logic [15:0]       run_length;
  logic [1:0]        prio_level;
  logic [DRAW_W-1:0] random_value;

  modport source (output valid, command, process_id, arrival_tick, run_length,
                  prio_level, random_value, input ready);
  modport sink   (input valid, command, process_id, arrival_tick, run_length,
                  prio_level, random_value, output ready);
endinterface

// Result channel: one item per selected, waiting or idle result.
interface lps_out_if;
  import lps_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        result_id;
  logic [TICK_W-1:0] tick_index;
  logic              last;

  modport source (output valid, kind, result_id, tick_index, last, input ready);
  modport sink   (input valid, kind, result_id, tick_index, last, output ready);
endinterface

// Configuration write channel.
interface lps_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// File: rtl/lottery_process_scheduler_unit.sv
// Load item: no result; the sequencer stays idle, so the next item is taken the cycle after.
// Tick item: the final result follows three walks over the table memory (ticket total,
// winner search, waiting list) and the remainder step; an idle tick ends after the
// ticket total walk.
// Output back-pressure adds stall cycles; the next item is taken once the final result is held.
// Reset (synchronous, rst_n low): empty table, tick counter 1, weights 1, 2 and 3.
`include "assert_macros.svh"

module lottery_process_scheduler_unit import lps_pkg::*; #(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lps_in_if.sink     in_ch,
  lps_out_if.source  out_ch,
  lps_cfg_if.sink    cfg_ch
);

  localparam int ADDR_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int TOT_W  = $clog2(WEIGHT_MAX * MAX_PROCS + 1);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [1:0]        w_low_r, w_norm_r, w_high_r;
  logic [DRAW_W-1:0] rnd_r, rnd_nxt;
  logic [CNT_W-1:0]  addr_r, addr_nxt;
  logic              vld_r, vld_nxt;
  logic [ADDR_W-1:0] eidx_r, eidx_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [TOT_W-1:0]  draw_r, draw_nxt;
  logic [TOT_W-1:0]  base_r, base_nxt;
  logic              found_r, found_nxt;
  logic [ADDR_W-1:0] win_idx_r, win_idx_nxt;
  entry_t            win_e_r, win_e_nxt;
  logic [1:0]        pend_kind_r, pend_kind_nxt;
  logic [7:0]        pend_id_r, pend_id_nxt;
  logic [RES_W-1:0]  n_r, n_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic [7:0]        out_id_r, out_id_nxt;
  logic [TICK_W-1:0] out_tick_r, out_tick_nxt;
  logic              out_last_r, out_last_nxt;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  entry_t            wr_data, rd_e;
  logic              mod_start, mod_done;
  logic [TOT_W-1:0]  mod_rem;
  logic [1:0]        tkt;
  logic              hit, qual, slot_free, in_acc, load_ok;
  entry_t            win_upd;

  // Process table memory.
  lps_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_PROCS),
    .AW    (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_e)
  );

  // Draw reduction modulo the ticket total.
  lps_mod #(
    .DVD_W (DRAW_W),
    .DVS_W (TOT_W)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (rnd_r),
    .divisor   (total_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Per-entry evaluation of the word just read.
  assign tkt  = entry_tickets(rd_e, tick_r, w_low_r, w_norm_r, w_high_r);
  assign hit  = (draw_r >= base_r) &&
                ((TOT_W+1)'(draw_r) < (TOT_W+1)'(base_r) + (TOT_W+1)'(tkt));
  assign qual = (eidx_r != win_idx_r) && entry_eligible(rd_e, tick_r);

  // An input item is taken only while the sequencer is idle.
  assign in_ch.ready = (state_r == ST_IDLE);

  // The output register can take a new item when empty or being drained.
  assign slot_free = !out_vld_r || out_ch.ready;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign load_ok   = cnt_r < CNT_W'(MAX_PROCS);

  // Winner after its run is charged one tick.
  always_comb begin
    win_upd           = win_e_r;
    win_upd.remaining = win_e_r.remaining - 16'd1;
    win_upd.done      = (win_e_r.remaining == 16'd1);
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    tick_nxt      = tick_r;
    rnd_nxt       = rnd_r;
    addr_nxt      = addr_r;
    vld_nxt       = 1'b0;
    eidx_nxt      = eidx_r;
    total_nxt     = total_r;
    draw_nxt      = draw_r;
    base_nxt      = base_r;
    found_nxt     = found_r;
    win_idx_nxt   = win_idx_r;
    win_e_nxt     = win_e_r;
    pend_kind_nxt = pend_kind_r;
    pend_id_nxt   = pend_id_r;
    n_nxt         = n_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_tick_nxt  = out_tick_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[ADDR_W-1:0];
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = addr_r[ADDR_W-1:0];
    mod_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.command == CMD_LOAD) begin
            // Append an entry unless the table is full.
            if (load_ok) begin
              wr_en             = 1'b1;
              wr_data.id        = in_ch.process_id;
              wr_data.arrival   = in_ch.arrival_tick;
              wr_data.remaining = in_ch.run_length;
              wr_data.prio      = in_ch.prio_level;
              wr_data.done      = (in_ch.run_length == 16'd0);
              cnt_nxt           = cnt_r + 1'b1;
            end
          end else begin
            rnd_nxt   = in_ch.random_value;
            addr_nxt  = '0;
            total_nxt = '0;
            state_nxt = ST_TOTAL;
          end
        end
      end

      ST_TOTAL: begin
        // Pipelined walk summing the tickets.
        if (addr_r < cnt_r) begin
          rd_en    = 1'b1;
          addr_nxt = addr_r + 1'b1;
          vld_nxt  = 1'b1;
          eidx_nxt = addr_r[ADDR_W-1:0];
        end
        if (vld_r) begin
          total_nxt = total_r + TOT_W'(tkt);
        end
        if (!vld_r && addr_r == cnt_r) begin
          if (total_r == '0) begin
            pend_kind_nxt = KIND_IDLE;
            pend_id_nxt   = 8'd0;
            n_nxt         = RES_W'(1);
            state_nxt     = ST_FINISH;
          end else begin
            mod_start = 1'b1;
            state_nxt = ST_DIVIDE;
          end
        end
      end

      ST_DIVIDE: begin
        if (mod_done) begin
          draw_nxt  = mod_rem;
          addr_nxt  = '0;
          base_nxt  = '0;
          found_nxt = 1'b0;
          state_nxt = ST_WINNER;
        end
      end

      ST_WINNER: begin
        // Pipelined walk for the holder of the drawn ticket.
        if (addr_r < cnt_r) begin
          rd_en    = 1'b1;
          addr_nxt = addr_r + 1'b1;
          vld_nxt  = 1'b1;
          eidx_nxt = addr_r[ADDR_W-1:0];
        end
        if (vld_r && !found_r) begin
          base_nxt = base_r + TOT_W'(tkt);
          if (hit) begin
            found_nxt   = 1'b1;
            win_idx_nxt = eidx_r;
            win_e_nxt   = rd_e;
          end
        end
        if (!vld_r && addr_r == cnt_r) begin
          state_nxt = ST_WRBACK;
        end
      end

      ST_WRBACK: begin
        wr_en         = 1'b1;
        wr_addr       = win_idx_r;
        wr_data       = win_upd;
        pend_kind_nxt = KIND_SELECTED;
        pend_id_nxt   = win_e_r.id;
        n_nxt         = RES_W'(1);
        addr_nxt      = '0;
        state_nxt     = ST_LIST_RD;
      end

      ST_LIST_RD: begin
        if (n_r < RES_W'(MAX_RESULTS) && addr_r < cnt_r) begin
          rd_en     = 1'b1;
          eidx_nxt  = addr_r[ADDR_W-1:0];
          addr_nxt  = addr_r + 1'b1;
          state_nxt = ST_LIST_EV;
        end else begin
          state_nxt = ST_FINISH;
        end
      end

      ST_LIST_EV: begin
        // A new waiting entry releases the held one as a non-final item.
        if (!qual) begin
          state_nxt = ST_LIST_RD;
        end else if (slot_free) begin
          out_vld_nxt   = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_id_nxt    = pend_id_r;
          out_tick_nxt  = tick_r;
          out_last_nxt  = 1'b0;
          pend_kind_nxt = KIND_WAITING;
          pend_id_nxt   = rd_e.id;
          n_nxt         = n_r + 1'b1;
          state_nxt     = ST_LIST_RD;
        end
      end

      ST_FINISH: begin
        if (slot_free) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = pend_kind_r;
          out_id_nxt   = pend_id_r;
          out_tick_nxt = tick_r;
          out_last_nxt = 1'b1;
          if (tick_r != {TICK_W{1'b1}}) begin
            tick_nxt = tick_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      tick_r    <= TICK_W'(1);
      vld_r     <= 1'b0;
      found_r   <= 1'b0;
      n_r       <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      tick_r    <= tick_nxt;
      vld_r     <= vld_nxt;
      found_r   <= found_nxt;
      n_r       <= n_nxt;
      out_vld_r <= out_vld_nxt;
    end
    rnd_r       <= rnd_nxt;
    addr_r      <= addr_nxt;
    eidx_r      <= eidx_nxt;
    total_r     <= total_nxt;
    draw_r      <= draw_nxt;
    base_r      <= base_nxt;
    win_idx_r   <= win_idx_nxt;
    win_e_r     <= win_e_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_id_r   <= pend_id_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_tick_r  <= out_tick_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Ticket weight registers; writes beyond the last index are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_low_r  <= 2'd1;
      w_norm_r <= 2'd2;
      w_high_r <= 2'd3;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        REG_LOW_WEIGHT:    w_low_r  <= cfg_ch.data;
        REG_NORMAL_WEIGHT: w_norm_r <= cfg_ch.data;
        REG_HIGH_WEIGHT:   w_high_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // Result channel.
  assign out_ch.valid      = out_vld_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.result_id  = out_id_r;
  assign out_ch.tick_index = out_tick_r;
  assign out_ch.last       = out_last_r;

  // The table never holds more entries than it has rows.
  `ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(MAX_PROCS),
    "entry count beyond table size")
  // A load into a table with room grows the count by one.
  `ASSERT_NEXT(a_load_grows, clk, rst_n,
    in_acc && in_ch.command == CMD_LOAD && load_ok, cnt_r == $past(cnt_r) + 1'b1,
    "load did not grow entry count")
  // The reduced draw always lies below the ticket total.
  `ASSERT_IMPL(a_draw_range, clk, rst_n, state_r == ST_WINNER, draw_r < total_r,
    "draw outside ticket range")
  // Write-back only follows a winner search that found a holder.
  `ASSERT_IMPL(a_winner_found, clk, rst_n, state_r == ST_WRBACK, found_r,
    "no winner at write-back")
  // The table is written only on a load or at the winner write-back.
  `ASSERT_IMPL(a_write_slot, clk, rst_n, wr_en,
    state_r == ST_IDLE || state_r == ST_WRBACK, "table write outside load or write-back")

endmodule

// File: rtl/lps_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module lps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/lps_mod.sv
// Restoring remainder unit: one dividend bit per cycle; done rises with the final remainder once the last bit is in.
module lps_mod #(
  parameter int DVD_W = 16,
  parameter int DVS_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVS_W-1:0] remainder
);

  localparam int STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W:0]    trial;

  // Shift the next dividend bit into the partial remainder.
  assign trial = {rem_r, dvd_r[DVD_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[DVS_W-1:0];
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
